// ===== src/display_init_sequence_interpreter_defines.svh =====
// ----------------------------------------------------------------------------
// Display init sequence interpreter: assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef DISPLAY_INIT_SEQUENCE_INTERPRETER_DEFINES_SVH
`define DISPLAY_INIT_SEQUENCE_INTERPRETER_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked property, disabled while reset is asserted
`define DIS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("display init interpreter: assertion failed");
// Clocked property, checked in reset too
`define DIS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("display init interpreter: assertion failed");
`else
`define DIS_ASSERT(label, clk, rst_n, prop)
`define DIS_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== src/dis_pkg.sv =====
// ----------------------------------------------------------------------------
// dis_pkg
// Shared widths, action codes and types of the display init interpreter.
// ----------------------------------------------------------------------------
`default_nettype none

package dis_pkg;

    localparam int unsigned SEQ_W     = 8;
    localparam int unsigned KIND_W    = 3;
    localparam int unsigned VAL_W     = 12;
    localparam int unsigned XY_W      = 16;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned RES_DEPTH = 4;

    // action kinds
    localparam logic [KIND_W-1:0] K_RST  = 3'd0;
    localparam logic [KIND_W-1:0] K_CS   = 3'd1;
    localparam logic [KIND_W-1:0] K_CD   = 3'd2;
    localparam logic [KIND_W-1:0] K_SEND = 3'd3;
    localparam logic [KIND_W-1:0] K_DUS  = 3'd4;
    localparam logic [KIND_W-1:0] K_DMS  = 3'd5;
    localparam logic [KIND_W-1:0] K_END  = 3'd6;
    localparam logic [KIND_W-1:0] K_BAD  = 3'd7;

    // one result item
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [VAL_W-1:0]  value;
        logic              last;
    } t_action;

    // results produced by one accepted item (0, 1 or 2)
    typedef struct packed {
        logic [1:0] cnt;
        t_action    a0;
        t_action    a1;
    } t_push;

endpackage

`default_nettype wire

// ===== src/dis_if.sv =====
// ----------------------------------------------------------------------------
// dis_if
// Valid/ready channels of the display init interpreter.
// ----------------------------------------------------------------------------
`default_nettype none

// sequence byte channel
interface dis_in_if;
    import dis_pkg::*;
    logic             valid;
    logic             ready;
    logic [SEQ_W-1:0] seq_byte;
    logic             start_req;
    modport source (output valid, output seq_byte, output start_req, input ready);
    modport sink   (input valid, input seq_byte, input start_req, output ready);
endinterface

// action channel
interface dis_out_if;
    import dis_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] action_kind;
    logic [VAL_W-1:0]  action_value;
    logic              last_of_run;
    modport source (output valid, output action_kind, output action_value,
                    output last_of_run, input ready);
    modport sink   (input valid, input action_kind, input action_value,
                    input last_of_run, output ready);
endinterface

// register write channel
interface dis_cfg_if;
    import dis_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [XY_W-1:0]      data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/dis_parse.sv =====
// ----------------------------------------------------------------------------
// dis_parse
// Byte decoder: parser state, line tracking and action generation.
// ----------------------------------------------------------------------------
`default_nettype none
`include "display_init_sequence_interpreter_defines.svh"

module dis_parse (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_accept,
    input  wire logic [dis_pkg::SEQ_W-1:0] i_seq_byte,
    input  wire logic                     i_start_req,
    input  wire logic [dis_pkg::XY_W-1:0] i_pixel_x,
    input  wire logic [dis_pkg::XY_W-1:0] i_pixel_y,
    output dis_pkg::t_push                o_push
);
    import dis_pkg::*;

    // opcode high nibbles
    localparam logic [3:0] OP_END    = 4'h0;
    localparam logic [3:0] OP_CMD_LO = 4'h1;
    localparam logic [3:0] OP_CMD_HI = 4'h3;
    localparam logic [3:0] OP_DATA   = 4'h6;
    localparam logic [3:0] OP_CDSTR  = 4'h7;
    localparam logic [3:0] OP_DMS    = 4'h8;
    localparam logic [3:0] OP_DUS    = 4'h9;
    localparam logic [3:0] OP_PX     = 4'hA;
    localparam logic [3:0] OP_PY     = 4'hB;
    localparam logic [3:0] OP_LINE   = 4'hF;

    // line control sub-codes (low nibble >> 2)
    localparam logic [1:0] Q_RST = 2'd0;
    localparam logic [1:0] Q_CS  = 2'd1;
    localparam logic [1:0] Q_CDM = 2'd3;

    // line bit positions
    localparam logic [1:0] LN_RST = 2'd0;
    localparam logic [1:0] LN_CS  = 2'd1;
    localparam logic [1:0] LN_CD  = 2'd2;

    typedef enum logic [3:0] {
        PH_IDLE, PH_OPC, PH_CMD, PH_ARG1, PH_ARG, PH_STR,
        PH_DMS, PH_DUS, PH_MASKX, PH_MASKY, PH_ORX, PH_ORY
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [3:0] r_lo, n_lo;
    logic [1:0] r_cmd, n_cmd;
    logic [3:0] r_other, n_other;
    logic [7:0] r_held, n_held;
    logic [1:0] r_cd_mode, n_cd_mode;
    logic [2:0] r_lvl, n_lvl;
    logic [2:0] r_init, n_init;

    logic [3:0]        hi, lo;
    logic              line_req, line_lvl, line_chg;
    logic [1:0]        line_bit;
    logic [KIND_W-1:0] line_kind;
    logic              snd_req;
    logic [KIND_W-1:0] snd_kind;
    logic [VAL_W-1:0]  snd_val;
    logic [3:0]        other_dec;
    logic [XY_W-1:0]   pos_shift;
    logic [VAL_W-1:0]  dly_cnt;
    t_action           line_act, snd_act;
    logic [1:0]        cnt;

    assign hi        = i_seq_byte[7:4];
    assign lo        = i_seq_byte[3:0];
    assign other_dec = r_other - 4'd1;
    assign dly_cnt   = {r_lo, i_seq_byte};
    assign pos_shift = ((r_phase == PH_ORX) ? i_pixel_x : i_pixel_y) >> r_lo;

    // decode: next state, at most one line change and one further action
    always_comb begin
        n_phase   = r_phase;
        n_lo      = r_lo;
        n_cmd     = r_cmd;
        n_other   = r_other;
        n_held    = r_held;
        n_cd_mode = r_cd_mode;
        line_req  = 1'b0;
        line_bit  = LN_CD;
        line_lvl  = 1'b0;
        snd_req   = 1'b0;
        snd_kind  = K_SEND;
        snd_val   = {4'd0, i_seq_byte};

        if (i_start_req || r_phase == PH_OPC) begin
            n_lo = lo;
            case (hi) inside
                OP_END: begin
                    snd_req  = 1'b1;
                    snd_kind = K_END;
                    snd_val  = '0;
                    n_phase  = PH_IDLE;
                end
                [OP_CMD_LO:OP_CMD_HI]: begin
                    line_req = 1'b1;
                    line_lvl = r_cd_mode[1];
                    n_cmd    = hi[1:0];
                    n_other  = lo;
                    n_phase  = PH_CMD;
                end
                OP_DATA, OP_CDSTR: begin
                    line_req = 1'b1;
                    line_lvl = (hi == OP_DATA) ? r_cd_mode[0] : ~r_cd_mode[1];
                    n_other  = lo;
                    n_phase  = (lo != 4'd0) ? PH_STR : PH_OPC;
                end
                OP_DMS: n_phase = PH_DMS;
                OP_DUS: n_phase = PH_DUS;
                OP_PX:  n_phase = PH_MASKX;
                OP_PY:  n_phase = PH_MASKY;
                OP_LINE: begin
                    case (lo[3:2])
                        Q_RST: begin
                            line_req = 1'b1;
                            line_bit = LN_RST;
                            line_lvl = lo[0];
                        end
                        Q_CS: begin
                            line_req = 1'b1;
                            line_bit = LN_CS;
                            line_lvl = lo[0];
                        end
                        Q_CDM:   n_cd_mode = lo[1:0];
                        default: ;
                    endcase
                    n_phase = PH_OPC;
                end
                default: begin
                    snd_req  = 1'b1;
                    snd_kind = K_BAD;
                    n_phase  = PH_IDLE;
                end
            endcase
        end else begin
            case (r_phase)
                PH_CMD: begin
                    snd_req = 1'b1;
                    n_cmd   = r_cmd - 2'd1;
                    if (r_cmd == 2'd1) begin
                        n_phase = (r_other != 4'd0) ? PH_ARG1 : PH_OPC;
                    end
                end
                PH_ARG1, PH_ARG, PH_STR: begin
                    line_req = (r_phase == PH_ARG1);
                    line_lvl = r_cd_mode[0];
                    snd_req  = 1'b1;
                    n_other  = other_dec;
                    if (other_dec == 4'd0) begin
                        n_phase = PH_OPC;
                    end else begin
                        n_phase = (r_phase == PH_STR) ? PH_STR : PH_ARG;
                    end
                end
                PH_DMS: begin
                    // a zero ms delay gives no action
                    snd_req  = (dly_cnt != '0);
                    snd_kind = K_DMS;
                    snd_val  = dly_cnt;
                    n_phase  = PH_OPC;
                end
                PH_DUS: begin
                    snd_req  = 1'b1;
                    snd_kind = K_DUS;
                    snd_val  = dly_cnt;
                    n_phase  = PH_OPC;
                end
                PH_MASKX, PH_MASKY: begin
                    n_held  = i_seq_byte;
                    n_phase = (r_phase == PH_MASKX) ? PH_ORX : PH_ORY;
                end
                PH_ORX, PH_ORY: begin
                    line_req = 1'b1;
                    line_lvl = r_cd_mode[0];
                    snd_req  = 1'b1;
                    snd_val  = {4'd0, (pos_shift[7:0] & r_held) | i_seq_byte};
                    n_phase  = PH_OPC;
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    // line tracking: emit only on first use or a level change
    always_comb begin
        line_chg = line_req && (!r_init[line_bit] || (r_lvl[line_bit] != line_lvl));
        n_lvl    = r_lvl;
        n_init   = r_init;
        if (line_chg) begin
            n_lvl[line_bit]  = line_lvl;
            n_init[line_bit] = 1'b1;
        end
        case (line_bit)
            LN_RST:  line_kind = K_RST;
            LN_CS:   line_kind = K_CS;
            default: line_kind = K_CD;
        endcase
    end

    // pack results, last flag on the final one
    always_comb begin
        cnt            = {1'b0, line_chg} + {1'b0, snd_req};
        line_act.kind  = line_kind;
        line_act.value = {{(VAL_W-1){1'b0}}, line_lvl};
        line_act.last  = !snd_req;
        snd_act.kind   = snd_kind;
        snd_act.value  = snd_val;
        snd_act.last   = 1'b1;
        o_push.cnt     = i_accept ? cnt : 2'd0;
        o_push.a0      = line_chg ? line_act : snd_act;
        o_push.a1      = snd_act;
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_lo      <= '0;
            r_cmd     <= '0;
            r_other   <= '0;
            r_held    <= '0;
            r_cd_mode <= '0;
            r_lvl     <= '0;
            r_init    <= '0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_lo      <= n_lo;
            r_cmd     <= n_cmd;
            r_other   <= n_other;
            r_held    <= n_held;
            r_cd_mode <= n_cd_mode;
            r_lvl     <= n_lvl;
            r_init    <= n_init;
        end
    end

    // a line holds a level only once it has been driven
    `DIS_ASSERT(a_lvl_init, i_clk, i_rst_n, (r_lvl & ~r_init) == 3'd0)
    // an end marker parks the parser
    `DIS_ASSERT(a_end_idle, i_clk, i_rst_n, (i_accept && i_start_req && i_seq_byte[7:4] == OP_END) |=> (r_phase == PH_IDLE))
    // two results: a line change first, then the final action
    `DIS_ASSERT(a_pair_order, i_clk, i_rst_n, (o_push.cnt == 2'd2) |-> (o_push.a0.kind <= K_CD && !o_push.a0.last && o_push.a1.last))
    // never three results
    `DIS_ASSERT(a_cnt_max, i_clk, i_rst_n, o_push.cnt != 2'd3)

endmodule

`default_nettype wire

// ===== src/dis_rfifo.sv =====
// ----------------------------------------------------------------------------
// dis_rfifo
// Small result queue: up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dis_rfifo #(
    parameter int unsigned DEPTH = dis_pkg::RES_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire dis_pkg::t_push i_push,
    input  wire logic       i_pop,
    output dis_pkg::t_action o_head,
    output logic            o_valid,
    output logic            o_room2
);
    import dis_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_action        r_mem [DEPTH];
    logic [PW-1:0]  r_wr, n_wr, wr_1;
    logic [PW-1:0]  r_rd, n_rd;
    logic [CW-1:0]  r_cnt, n_cnt;

    function automatic logic [PW-1:0] f_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign wr_1    = f_inc(r_wr);
    assign o_head  = r_mem[r_rd];
    assign o_valid = (r_cnt != '0);
    assign o_room2 = (r_cnt <= CW'(DEPTH - 2));

    // pointer and fill updates
    always_comb begin
        case (i_push.cnt)
            2'd1:    n_wr = wr_1;
            2'd2:    n_wr = f_inc(wr_1);
            default: n_wr = r_wr;
        endcase
        n_rd  = i_pop ? f_inc(r_rd) : r_rd;
        n_cnt = r_cnt + CW'(i_push.cnt) - CW'(i_pop);
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.a0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_1] <= i_push.a1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ===== src/display_init_sequence_interpreter.sv =====
// ----------------------------------------------------------------------------
// display_init_sequence_interpreter
// Decodes a byte-coded display init sequence into line, send and delay actions.
// ----------------------------------------------------------------------------
//  channel   dir   payload                                      handshake
//  i_in      in    seq_byte[7:0], start_req                     valid/ready
//  o_out     out   action_kind[2:0], action_value[11:0],        valid/ready
//                  last_of_run
//  i_cfg     in    index[0] (0 pixel_x, 1 pixel_y), data[15:0]  valid/ready
//
//  One byte is decoded per cycle while i_in.ready is high; its actions are
//  written into the result queue and leave on o_out in order, behind older ones.
//  i_in.ready drops while the result queue holds more than DEPTH-2 actions;
//  output stalls back up into the queue only. i_cfg is always ready.
//  Synchronous reset: parser idle, lines uninitialized, queue empty.
// ----------------------------------------------------------------------------
`default_nettype none

module display_init_sequence_interpreter #(
    parameter int unsigned RES_DEPTH = dis_pkg::RES_DEPTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dis_in_if.sink     i_in,
    dis_out_if.source  o_out,
    dis_cfg_if.sink    i_cfg
);
    import dis_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_X = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_Y = 1'd1;

    logic            [XY_W-1:0] r_pixel_x;
    logic            [XY_W-1:0] r_pixel_y;
    logic            in_accept;
    logic            room2;
    t_push           push;
    t_action         head;

    assign i_in.ready = room2;
    assign in_accept  = i_in.valid && room2;
    assign i_cfg.ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_x <= '0;
            r_pixel_y <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_PIXEL_X: r_pixel_x <= i_cfg.data;
                CFG_PIXEL_Y: r_pixel_y <= i_cfg.data;
                default:     ;
            endcase
        end
    end

    // decoder
    dis_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_seq_byte  (i_in.seq_byte),
        .i_start_req (i_in.start_req),
        .i_pixel_x   (r_pixel_x),
        .i_pixel_y   (r_pixel_y),
        .o_push      (push)
    );

    // result queue
    dis_rfifo #(
        .DEPTH (RES_DEPTH)
    ) u_rfifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_out.valid && o_out.ready),
        .o_head  (head),
        .o_valid (o_out.valid),
        .o_room2 (room2)
    );

    assign o_out.action_kind  = head.kind;
    assign o_out.action_value = head.value;
    assign o_out.last_of_run  = head.last;

endmodule

`default_nettype wire
